[sv/epwa_pkg.sv]
// Shared widths, codes, constants and types of the edge pulse-width analyzer.
// Used by edge_pulse_width_analyzer and its port checker; no dependencies.
`default_nettype none

package epwa_pkg;

	localparam int CHANNELS_DEF = 4;

	localparam int TS_W       = 32;
	localparam int REV_W      = 16;
	localparam int TOOTH_W    = 8;
	localparam int CHAN_W     = 2;
	localparam int EN_W       = 4;
	localparam int DUTY_W     = 16;
	localparam int FREQ_W     = 20;
	localparam int PROD_W     = 46;
	localparam int CNT_W      = $clog2(PROD_W + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [TS_W-1:0]      EXPIRY_RESET = 32'd4000000;
	localparam logic [13:0]          DUTY_SCALE   = 14'd10000;
	localparam logic [FREQ_W-1:0]    FREQ_NUM     = 20'd1000000;

	localparam logic                 KIND_EDGE  = 1'b0;
	localparam logic                 KIND_TOOTH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXPIRY         = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EXPIRE,
		ST_MULT,
		ST_DIV_DUTY,
		ST_DIV_FREQ,
		ST_FINISH
	} epwa_state_t;

	typedef struct packed {
		logic [CHAN_W-1:0] report_channel;
		logic              channel_active;
		logic [TS_W-1:0]   high_width;
		logic [TS_W-1:0]   low_width;
		logic [TS_W-1:0]   period;
		logic [TS_W-1:0]   prev_total_on;
		logic [TS_W-1:0]   wave_offset;
		logic [TS_W-1:0]   rise_count;
		logic [TS_W-1:0]   fall_count;
		logic [TS_W-1:0]   engine_cycle;
		logic [DUTY_W-1:0] duty;
		logic [FREQ_W-1:0] freq;
	} report_t;

endpackage

`default_nettype wire

[sv/edge_pulse_width_analyzer.sv]
// Top level of the edge pulse-width analyzer: per-channel edge state, sequencer
// and shared bit-serial divider. Depends on epwa_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction: a
//   timestamped edge on a channel (kind = edge) or an engine-trigger tooth
//   (kind = tooth). Every accepted event yields exactly one report on the
//   output channel (out_valid/out_ready) for the addressed channel.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data):
//   index 0 is the channel enable mask, index 1 the expiry time in us.
//   Write it only while no event is in flight.
//   An event passes the update, expiry, multiply, duty-divide,
//   frequency-divide and finish states in order; a new event is taken only
//   once the last report is loaded. The single restoring divider runs 46
//   steps for duty and then 20 steps for frequency. A disabled channel or a
//   zero period skips the divider and goes from multiply straight to finish.
//   Reset clears all channel state, the enable mask (all off) and sets the
//   expiry time to 4 s. A stalled receiver holds the report in the output
//   register; the block still takes the next event and holds its finished
//   report internally until the output register frees up.
`default_nettype none

module edge_pulse_width_analyzer #(
	parameter int CHANNELS = epwa_pkg::CHANNELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             cfg_we,
	input  wire logic [epwa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [epwa_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             kind,
	input  wire logic [epwa_pkg::CHAN_W-1:0]      channel,
	input  wire logic                             level,
	input  wire logic [epwa_pkg::TS_W-1:0]        timestamp_us,
	input  wire logic [epwa_pkg::REV_W-1:0]       revolution_count,
	input  wire logic [epwa_pkg::TOOTH_W-1:0]     tooth_index,

	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [epwa_pkg::CHAN_W-1:0]           report_channel,
	output logic                                  channel_active,
	output logic [epwa_pkg::TS_W-1:0]             high_width_us,
	output logic [epwa_pkg::TS_W-1:0]             low_width_us,
	output logic [epwa_pkg::TS_W-1:0]             period_us,
	output logic [epwa_pkg::TS_W-1:0]             prev_total_on_us,
	output logic [epwa_pkg::TS_W-1:0]             wave_offset_us,
	output logic [epwa_pkg::TS_W-1:0]             rise_count,
	output logic [epwa_pkg::TS_W-1:0]             fall_count,
	output logic [epwa_pkg::TS_W-1:0]             engine_cycle_us,
	output logic [epwa_pkg::DUTY_W-1:0]           duty_hundredths,
	output logic [epwa_pkg::FREQ_W-1:0]           freq_hz
);
	import epwa_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Configuration registers
	logic [EN_W-1:0] channel_enable_q;
	logic [TS_W-1:0] expiry_q;

	// Per-channel measurement state
	logic [TS_W-1:0]  rise_time_q      [CHANNELS];
	logic [TS_W-1:0]  fall_time_q      [CHANNELS];
	logic [TS_W-1:0]  last_activity_q  [CHANNELS];
	logic [TS_W-1:0]  high_width_q     [CHANNELS];
	logic [TS_W-1:0]  low_width_q      [CHANNELS];
	logic [TS_W-1:0]  period_q         [CHANNELS];
	logic [TS_W-1:0]  on_acc_q         [CHANNELS];
	logic [TS_W-1:0]  prev_total_on_q  [CHANNELS];
	logic [TS_W-1:0]  wave_offset_q    [CHANNELS];
	logic [REV_W-1:0] seen_rev_q       [CHANNELS];
	logic [TS_W-1:0]  rises_seen_q     [CHANNELS];
	logic [TS_W-1:0]  falls_seen_q     [CHANNELS];
	logic [TS_W-1:0]  cycle_start_q;
	logic [TS_W-1:0]  cycle_duration_q;

	// Captured event
	logic               kind_q;
	logic [CHAN_W-1:0]  chan_q;
	logic               level_q;
	logic [TS_W-1:0]    now_q;
	logic [REV_W-1:0]   rev_q;
	logic [TOOTH_W-1:0] tooth_q;
	logic               act_q;

	// Sequencer and divider
	epwa_state_t      state_q, state_d;
	logic [CNT_W-1:0] div_cnt_q;
	logic [PROD_W-1:0] div_n_q;
	logic [TS_W-1:0]  div_r_q;
	report_t          res_q;
	report_t          out_q;
	logic             out_valid_q;

	logic             accept;
	logic             out_free;
	logic             load_out;
	logic             div_last;

	logic [IDX_W-1:0] idx;
	logic             act_in;
	logic [TS_W-1:0]  fall_w;
	logic [TS_W-1:0]  acc_sum;
	logic [TS_W-1:0]  elapsed;
	logic             expired;
	logic [PROD_W-1:0] prod;

	logic [TS_W:0]     div_t;
	logic [TS_W:0]     div_sub;
	logic              div_ge;
	logic [TS_W-1:0]   div_r_next;
	logic [PROD_W-1:0] div_n_next;
	logic [DUTY_W-1:0] duty_sat;

	assign idx     = IDX_W'(chan_q);
	assign act_in  = (32'(channel) < 32'(CHANNELS)) && channel_enable_q[channel];
	assign fall_w  = now_q - rise_time_q[idx];
	assign acc_sum = on_acc_q[idx] + fall_w;
	assign elapsed = now_q - last_activity_q[idx];
	assign expired = elapsed > expiry_q;
	assign prod    = PROD_W'(res_q.high_width) * PROD_W'(DUTY_SCALE);

	// One restoring step: shift in the next dividend bit, subtract when it fits.
	assign div_t      = {div_r_q, div_n_q[PROD_W-1]};
	assign div_sub    = div_t - {1'b0, res_q.period};
	assign div_ge     = !div_sub[TS_W];
	assign div_r_next = div_ge ? div_sub[TS_W-1:0] : div_t[TS_W-1:0];
	assign div_n_next = {div_n_q[PROD_W-2:0], div_ge};
	assign duty_sat   = (|div_n_next[PROD_W-1:DUTY_W]) ? '1 : div_n_next[DUTY_W-1:0];

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign div_last = (div_cnt_q == CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE:  state_d = ST_EXPIRE;
			ST_EXPIRE:  state_d = ST_MULT;
			ST_MULT: begin
				// Disabled channels report a zero period, so both skip the divider.
				if (res_q.period == '0) state_d = ST_FINISH;
				else                    state_d = ST_DIV_DUTY;
			end
			ST_DIV_DUTY: begin
				if (div_last) state_d = ST_DIV_FREQ;
			end
			ST_DIV_FREQ: begin
				if (div_last) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_FINISH: load_out = out_free;
			default: begin
				in_ready = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_MULT:     div_cnt_q <= CNT_W'(PROD_W);
				ST_DIV_DUTY: div_cnt_q <= div_last ? CNT_W'(FREQ_W) : div_cnt_q - CNT_W'(1);
				ST_DIV_FREQ: div_cnt_q <= div_cnt_q - CNT_W'(1);
				default:     div_cnt_q <= div_cnt_q;
			endcase
			if (load_out)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Configuration and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_enable_q <= '0;
			expiry_q         <= EXPIRY_RESET;
			cycle_start_q    <= '0;
			cycle_duration_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				rise_time_q[i]     <= '0;
				fall_time_q[i]     <= '0;
				last_activity_q[i] <= '0;
				high_width_q[i]    <= '0;
				low_width_q[i]     <= '0;
				period_q[i]        <= '0;
				on_acc_q[i]        <= '0;
				prev_total_on_q[i] <= '0;
				wave_offset_q[i]   <= '0;
				seen_rev_q[i]      <= '0;
				rises_seen_q[i]    <= '0;
				falls_seen_q[i]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CHANNEL_ENABLE: channel_enable_q <= cfg_data[EN_W-1:0];
					REG_EXPIRY:         expiry_q         <= cfg_data[TS_W-1:0];
					default:            expiry_q         <= expiry_q;
				endcase
			end
			if (state_q == ST_UPDATE) begin
				if (kind_q == KIND_TOOTH) begin
					// Only the first tooth opens an engine cycle.
					if (tooth_q == '0) begin
						cycle_duration_q <= now_q - cycle_start_q;
						cycle_start_q    <= now_q;
					end
				end else if (act_q) begin
					last_activity_q[idx] <= now_q;
					if (level_q) begin
						rises_seen_q[idx] <= rises_seen_q[idx] + TS_W'(1);
						low_width_q[idx]  <= now_q - fall_time_q[idx];
						period_q[idx]     <= now_q - rise_time_q[idx];
						rise_time_q[idx]  <= now_q;
					end else begin
						falls_seen_q[idx] <= falls_seen_q[idx] + TS_W'(1);
						high_width_q[idx] <= fall_w;
						fall_time_q[idx]  <= now_q;
						// A new revolution latches the running total and restarts it.
						if (seen_rev_q[idx] != rev_q) begin
							seen_rev_q[idx]      <= rev_q;
							prev_total_on_q[idx] <= acc_sum;
							on_acc_q[idx]        <= '0;
							wave_offset_q[idx]   <= now_q - cycle_start_q;
						end else begin
							on_acc_q[idx] <= acc_sum;
						end
					end
				end
			end
		end
	end

	// Event capture, report assembly and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			chan_q  <= channel;
			level_q <= level;
			now_q   <= timestamp_us;
			rev_q   <= revolution_count;
			tooth_q <= tooth_index;
			act_q   <= act_in;
		end
		case (state_q)
			ST_EXPIRE: begin
				res_q.report_channel <= chan_q;
				res_q.channel_active <= act_q;
				res_q.engine_cycle   <= cycle_duration_q;
				res_q.high_width     <= (act_q && !expired) ? high_width_q[idx] : '0;
				res_q.low_width      <= act_q ? low_width_q[idx]     : '0;
				res_q.period         <= act_q ? period_q[idx]        : '0;
				res_q.prev_total_on  <= act_q ? prev_total_on_q[idx] : '0;
				res_q.wave_offset    <= act_q ? wave_offset_q[idx]   : '0;
				res_q.rise_count     <= act_q ? rises_seen_q[idx]    : '0;
				res_q.fall_count     <= act_q ? falls_seen_q[idx]    : '0;
				res_q.duty           <= '0;
				res_q.freq           <= '0;
			end
			ST_MULT: begin
				div_n_q <= prod;
				div_r_q <= '0;
			end
			ST_DIV_DUTY: begin
				if (div_last) begin
					// Latch duty, then load the frequency numerator left-aligned.
					res_q.duty <= duty_sat;
					div_n_q    <= {FREQ_NUM, (PROD_W - FREQ_W)'(0)};
					div_r_q    <= '0;
				end else begin
					div_n_q <= div_n_next;
					div_r_q <= div_r_next;
				end
			end
			ST_DIV_FREQ: begin
				div_n_q <= div_n_next;
				div_r_q <= div_r_next;
				if (div_last) res_q.freq <= div_n_next[FREQ_W-1:0];
			end
			default: begin
				div_n_q <= div_n_q;
			end
		endcase
		if (load_out) out_q <= res_q;
	end

	assign out_valid        = out_valid_q;
	assign report_channel   = out_q.report_channel;
	assign channel_active   = out_q.channel_active;
	assign high_width_us    = out_q.high_width;
	assign low_width_us     = out_q.low_width;
	assign period_us        = out_q.period;
	assign prev_total_on_us = out_q.prev_total_on;
	assign wave_offset_us   = out_q.wave_offset;
	assign rise_count       = out_q.rise_count;
	assign fall_count       = out_q.fall_count;
	assign engine_cycle_us  = out_q.engine_cycle;
	assign duty_hundredths  = out_q.duty;
	assign freq_hz          = out_q.freq;

endmodule

`default_nettype wire

[sv/epwa_checker.sv]
// Port-level checker for edge_pulse_width_analyzer, bound to the top level.
// Depends on epwa_pkg for field widths.
`default_nettype none

module epwa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          channel_active,
	input wire logic [epwa_pkg::TS_W-1:0]     high_width_us,
	input wire logic [epwa_pkg::TS_W-1:0]     period_us,
	input wire logic [epwa_pkg::DUTY_W-1:0]   duty_hundredths,
	input wire logic [epwa_pkg::FREQ_W-1:0]   freq_hz
);
	import epwa_pkg::*;

	// Drop ready after a transaction: one event is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an input transaction");

	// Hold a stalled report.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(period_us)
			&& $stable(duty_hundredths) && $stable(freq_hz))
		else $error("stalled report changed");

	// Report zeros for a disabled channel.
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !channel_active |-> high_width_us == '0 && period_us == '0
			&& duty_hundredths == '0 && freq_hz == '0)
		else $error("disabled channel reported nonzero measurements");

	// Report no duty or frequency without a period.
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && period_us == '0 |-> duty_hundredths == '0 && freq_hz == '0)
		else $error("duty or frequency nonzero for zero period");

endmodule

bind edge_pulse_width_analyzer epwa_checker u_epwa_checker (.*);

`default_nettype wire
